// ===== hw/rtl/ppos_pkg.sv =====
package ppos_pkg;

  // Fraction bits kept on the vector length
  localparam int LEN_FRAC = 16;

  // Configuration register map
  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_t;

endpackage

// ===== hw/rtl/project_point_onto_sphere_unit.sv =====
// Projects one signed fixed-point vertex per beat onto a sphere of configured
// centre and radius: out = centre + (in - centre) * radius / |in - centre|,
// rounded half up and saturated to the coordinate range. A vertex equal to the
// centre returns the centre with out_zero_offset set. The block accepts one
// vertex every cycle while no result waits on out_ready and delivers one
// result per vertex, in order: three stages form the
// offset, squares and radius products, COORD_WIDTH+17 stages run the
// digit-by-digit square root of the length, COORD_WIDTH+3 stages run the
// restoring division per axis, and one stage rounds and clamps. The whole
// pipeline holds while a result waits on out_ready. Configuration writes take
// effect at once and belong between streams, when no vertex is in flight.
module project_point_onto_sphere_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  ppos_pkg::cfg_idx_t       cfg_index,
  input  logic [COORD_WIDTH-1:0]   cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COORD_WIDTH-1:0]   in_x,
  input  logic [COORD_WIDTH-1:0]   in_y,
  input  logic [COORD_WIDTH-1:0]   in_z,
  input  logic                     in_last_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COORD_WIDTH-1:0]   out_x,
  output logic [COORD_WIDTH-1:0]   out_y,
  output logic [COORD_WIDTH-1:0]   out_z,
  output logic                     out_zero_offset,
  output logic                     out_saturated,
  output logic                     out_last_out
);
  import ppos_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int AW = W + 1;             // offset magnitude
  localparam int PW = 2 * W;             // |d| * radius
  localparam int SW = 2 * W + 2;         // sum of squares
  localparam int R  = W + 17;            // root bits
  localparam int RW = R + 2;             // sqrt remainder
  localparam int Q  = W + 2;             // quotient bits
  localparam int DW = R + 1;             // divider remainder
  localparam int NW = PW + LEN_FRAC + 1; // dividend
  localparam int VW = W + 4;             // signed sum before clamp

  typedef struct packed {
    logic                   last;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][PW-1:0]     prod;
  } meta_t;

  // Configuration registers
  logic [W-1:0]   cx_r, cy_r, cz_r;
  logic [W-2:0]   rad_r;
  logic [2:0][W-1:0] cen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= (W-1)'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: cx_r  <= cfg_wdata;
        CFG_CENTER_Y: cy_r  <= cfg_wdata;
        CFG_CENTER_Z: cz_r  <= cfg_wdata;
        CFG_RADIUS:   rad_r <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  assign cen = {cz_r, cy_r, cx_r};

  // Global advance: everything moves unless a result is held
  logic en;
  logic out_vld_r;
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  // Stage A: offset sign and magnitude
  logic [2:0][W-1:0]  inv;
  logic [2:0][AW-1:0] abs_nxt;
  logic [2:0]         neg_nxt;
  logic               a_vld_r, a_last_r;
  logic [2:0][AW-1:0] a_abs_r;
  logic [2:0]         a_neg_r;

  assign inv = {in_z, in_y, in_x};

  always_comb begin
    logic [AW-1:0] d;
    for (int a = 0; a < 3; a++) begin
      d = {inv[a][W-1], inv[a]} - {cen[a][W-1], cen[a]};
      neg_nxt[a] = d[AW-1];
      abs_nxt[a] = d[AW-1] ? (~d + 1'b1) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_abs_r  <= abs_nxt;
      a_neg_r  <= neg_nxt;
      a_last_r <= in_last_in;
    end
  end

  // Stage B: squares and radius products
  logic               b_vld_r, b_last_r;
  logic [2:0]         b_neg_r;
  logic [2:0][SW-1:0] b_sq_r;
  logic [2:0][PW-1:0] b_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        b_sq_r[a]   <= SW'(a_abs_r[a]) * SW'(a_abs_r[a]);
        b_prod_r[a] <= PW'(a_abs_r[a]) * PW'(rad_r);
      end
      b_neg_r  <= a_neg_r;
      b_last_r <= a_last_r;
    end
  end

  // Stage C feeds square-root slot 0: sum of squares
  logic [SW-1:0] s_nxt;
  assign s_nxt = b_sq_r[0] + b_sq_r[1] + b_sq_r[2];

  logic              sq_vld_r  [0:R];
  logic [SW-1:0]     sq_s_r    [0:R];
  logic [RW-1:0]     sq_rem_r  [0:R];
  logic [R-1:0]      sq_root_r [0:R];
  meta_t             sq_mt_r   [0:R];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else if (en) sq_vld_r[0] <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s_r[0]       <= s_nxt;
      sq_rem_r[0]     <= '0;
      sq_root_r[0]    <= '0;
      sq_mt_r[0].last <= b_last_r;
      sq_mt_r[0].zero <= (s_nxt == '0);
      sq_mt_r[0].neg  <= b_neg_r;
      sq_mt_r[0].prod <= b_prod_r;
    end
  end

  // Square root: one root bit per stage of S * 2^(2*LEN_FRAC)
  for (genvar k = 0; k < R; k++) begin : g_sqrt
    logic [2*R-1:0] xk;
    logic [RW-1:0]  rsh, trial;
    logic           ge;

    assign xk    = (2*R)'(sq_s_r[k]) << (2*LEN_FRAC);
    assign rsh   = {sq_rem_r[k][RW-3:0], xk[2*(R-1-k) +: 2]};
    assign trial = {sq_root_r[k], 2'b01};
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[k+1] <= 1'b0;
      else if (en) sq_vld_r[k+1] <= sq_vld_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= ge ? (rsh - trial) : rsh;
        sq_root_r[k+1] <= {sq_root_r[k][R-2:0], ge};
        sq_s_r[k+1]    <= sq_s_r[k];
        sq_mt_r[k+1]   <= sq_mt_r[k];
      end
    end
  end

  // Divider slot 0: load length and the dividend's top bits
  logic              dv_vld_r [0:Q];
  logic [R-1:0]      dv_len_r [0:Q];
  logic [2:0][DW-1:0] dv_rem_r [0:Q];
  logic [2:0][Q-1:0] dv_q_r   [0:Q];
  meta_t             dv_mt_r  [0:Q];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (en) dv_vld_r[0] <= sq_vld_r[R];
  end

  always_ff @(posedge clk) begin
    logic [NW-1:0] n;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        n = {sq_mt_r[R].prod[a], {(LEN_FRAC+1){1'b0}}};
        dv_rem_r[0][a] <= DW'(n >> Q);
      end
      dv_q_r[0]   <= '0;
      dv_len_r[0] <= sq_root_r[R];
      dv_mt_r[0]  <= sq_mt_r[R];
    end
  end

  // Restoring division: one quotient bit per stage, three axes side by side
  for (genvar j = 0; j < Q; j++) begin : g_div
    logic [2:0][DW-1:0] rem_nxt;
    logic [2:0][Q-1:0]  q_nxt;

    always_comb begin
      logic [NW-1:0] n;
      logic [DW-1:0] rsh;
      logic          ge;
      for (int a = 0; a < 3; a++) begin
        n   = {dv_mt_r[j].prod[a], {(LEN_FRAC+1){1'b0}}};
        rsh = {dv_rem_r[j][a][DW-2:0], n[Q-1-j]};
        ge  = (rsh >= {1'b0, dv_len_r[j]});
        rem_nxt[a] = ge ? (rsh - {1'b0, dv_len_r[j]}) : rsh;
        q_nxt[a]   = {dv_q_r[j][a][Q-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[j+1] <= 1'b0;
      else if (en) dv_vld_r[j+1] <= dv_vld_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j+1] <= rem_nxt;
        dv_q_r[j+1]   <= q_nxt;
        dv_len_r[j+1] <= dv_len_r[j];
        dv_mt_r[j+1]  <= dv_mt_r[j];
      end
    end
  end

  // Output stage: round half up, add centre, clamp
  logic [2:0][W-1:0] res_nxt;
  logic              sat_nxt;

  always_comb begin
    logic [Q:0]            mag;
    logic signed [VW-1:0]  cv, mv, vv, hi, lo;
    hi = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};
    sat_nxt = 1'b0;
    for (int a = 0; a < 3; a++) begin
      mag = ({1'b0, dv_q_r[Q][a]} + 1'b1) >> 1;
      cv  = {{(VW-W){cen[a][W-1]}}, cen[a]};
      mv  = {{(VW-Q-1){1'b0}}, mag};
      vv  = dv_mt_r[Q].neg[a] ? (cv - mv) : (cv + mv);
      if (dv_mt_r[Q].zero) begin
        res_nxt[a] = cen[a];
      end else if (vv > hi) begin
        res_nxt[a] = hi[W-1:0];
        sat_nxt    = 1'b1;
      end else if (vv < lo) begin
        res_nxt[a] = lo[W-1:0];
        sat_nxt    = 1'b1;
      end else begin
        res_nxt[a] = vv[W-1:0];
      end
    end
  end

  logic [2:0][W-1:0] res_r;
  logic              zero_r, sat_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= dv_vld_r[Q];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      zero_r <= dv_mt_r[Q].zero;
      sat_r  <= sat_nxt && !dv_mt_r[Q].zero;
      last_r <= dv_mt_r[Q].last;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_x           = res_r[0];
  assign out_y           = res_r[1];
  assign out_z           = res_r[2];
  assign out_zero_offset = zero_r;
  assign out_saturated   = sat_r;
  assign out_last_out    = last_r;

endmodule

// ===== hw/rtl/ppos_checker.sv =====
module ppos_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   cfg_we,
  input ppos_pkg::cfg_idx_t     cfg_index,
  input logic [COORD_WIDTH-1:0] cfg_wdata,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [COORD_WIDTH-1:0] in_x,
  input logic [COORD_WIDTH-1:0] in_y,
  input logic [COORD_WIDTH-1:0] in_z,
  input logic                   in_last_in,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_x,
  input logic [COORD_WIDTH-1:0] out_y,
  input logic [COORD_WIDTH-1:0] out_z,
  input logic                   out_zero_offset,
  input logic                   out_saturated,
  input logic                   out_last_out
);
  import ppos_pkg::*;

  // Shadow of the centre registers
  logic [COORD_WIDTH-1:0] cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: cx_r <= cfg_wdata;
        CFG_CENTER_Y: cy_r <= cfg_wdata;
        CFG_CENTER_Z: cz_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_last_out))
    else $error("result beat changed while stalled");

  // Zero offset returns the centre
  a_zero_centre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_offset |-> out_x == cx_r && out_y == cy_r && out_z == cz_r)
    else $error("zero offset result differs from centre");

  // Zero offset is never flagged saturated
  a_zero_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_offset |-> !out_saturated)
    else $error("zero offset with saturation");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind project_point_onto_sphere_unit ppos_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ppos_checker (.*);
